// File: sv/hcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder package
// Shared widths, codes, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int SYM_W     = 8;
	localparam int NODE_W    = 9;
	localparam int FREQ_W    = 24;
	localparam int WEIGHT_W  = 32;
	localparam int CODE_W    = 32;
	localparam int LEN_W     = 6;
	localparam int PLEN_W    = 9;
	localparam int MAX_CODE_LEN = 32;
	localparam int NUM_SYMBOLS  = 1 << SYM_W;
	localparam int NUM_NODES    = 2 * NUM_SYMBOLS - 1;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_BUILD  = 2'd1,
		ACT_READ   = 2'd2,
		ACT_DECODE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_TOO_LONG  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LOAD,
		S_RD_A,
		S_RD_B,
		S_DEC_A,
		S_DEC_B,
		S_DEC_C,
		S_B_INIT,
		S_LEAF_RD,
		S_LEAF_WR,
		S_B_CHECK,
		S_SCAN_START,
		S_SCAN,
		S_REMOVE,
		S_MOVE,
		S_MERGE,
		S_B_ROOT,
		S_P_RD,
		S_P_EVAL,
		S_P_ONE,
		S_P_DONE
	} state_t;

	typedef struct packed {
		state_t op;
		logic   accept;
	} cmd_t;

	typedef struct packed {
		logic sym_last;
		logic pool_empty;
		logic pool_one;
		logic scan_last;
		logic second;
		logic built;
		logic root_leaf;
		logic node_leaf;
		logic idx_zero;
	} sts_t;

	typedef struct packed {
		logic [NODE_W-1:0] c0;
		logic [NODE_W-1:0] c1;
		logic              leaf;
		logic [SYM_W-1:0]  sym;
	} node_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [NODE_W-1:0]   idx;
	} pool_t;

	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [PLEN_W-1:0] len;
	} path_t;

	typedef struct packed {
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} code_t;

endpackage
`default_nettype wire

// File: sv/hcb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder controller
// Sequences loads, code reads, decode steps and the multi-phase tree build.
// ----------------------------------------------------------------------------
module hcb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        action,
	input  wire hcb_pkg::sts_t     sts,
	output hcb_pkg::cmd_t          cmd,
	output logic                   busy
);

	hcb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.op     = state_q;
		cmd.accept = 1'b0;
		busy       = (state_q != hcb_pkg::S_IDLE);
		case (state_q)
			hcb_pkg::S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					case (action)
						hcb_pkg::ACT_LOAD:  state_d = hcb_pkg::S_LOAD;
						hcb_pkg::ACT_BUILD: state_d = hcb_pkg::S_B_INIT;
						hcb_pkg::ACT_READ:  state_d = hcb_pkg::S_RD_A;
						default:            state_d = hcb_pkg::S_DEC_A;
					endcase
				end
			end
			hcb_pkg::S_LOAD:  state_d = hcb_pkg::S_IDLE;
			hcb_pkg::S_RD_A:  state_d = hcb_pkg::S_RD_B;
			hcb_pkg::S_RD_B:  state_d = hcb_pkg::S_IDLE;
			hcb_pkg::S_DEC_A: begin
				if (!sts.built || sts.root_leaf) begin
					state_d = hcb_pkg::S_IDLE;
				end else begin
					state_d = hcb_pkg::S_DEC_B;
				end
			end
			hcb_pkg::S_DEC_B:   state_d = hcb_pkg::S_DEC_C;
			hcb_pkg::S_DEC_C:   state_d = hcb_pkg::S_IDLE;
			hcb_pkg::S_B_INIT:  state_d = hcb_pkg::S_LEAF_RD;
			hcb_pkg::S_LEAF_RD: state_d = hcb_pkg::S_LEAF_WR;
			hcb_pkg::S_LEAF_WR: begin
				state_d = sts.sym_last ? hcb_pkg::S_B_CHECK : hcb_pkg::S_LEAF_RD;
			end
			hcb_pkg::S_B_CHECK: begin
				if (sts.pool_empty) begin
					state_d = hcb_pkg::S_IDLE;
				end else if (sts.pool_one) begin
					state_d = hcb_pkg::S_B_ROOT;
				end else begin
					state_d = hcb_pkg::S_SCAN_START;
				end
			end
			hcb_pkg::S_SCAN_START: state_d = hcb_pkg::S_SCAN;
			hcb_pkg::S_SCAN: begin
				if (sts.scan_last) begin
					state_d = hcb_pkg::S_REMOVE;
				end
			end
			hcb_pkg::S_REMOVE: state_d = hcb_pkg::S_MOVE;
			hcb_pkg::S_MOVE: begin
				state_d = sts.second ? hcb_pkg::S_MERGE : hcb_pkg::S_SCAN_START;
			end
			hcb_pkg::S_MERGE: begin
				state_d = sts.pool_empty ? hcb_pkg::S_B_ROOT : hcb_pkg::S_SCAN_START;
			end
			hcb_pkg::S_B_ROOT: state_d = hcb_pkg::S_P_RD;
			hcb_pkg::S_P_RD:   state_d = hcb_pkg::S_P_EVAL;
			hcb_pkg::S_P_EVAL: begin
				if (!sts.node_leaf) begin
					state_d = hcb_pkg::S_P_ONE;
				end else if (sts.idx_zero) begin
					state_d = hcb_pkg::S_P_DONE;
				end else begin
					state_d = hcb_pkg::S_P_RD;
				end
			end
			hcb_pkg::S_P_ONE: begin
				state_d = sts.idx_zero ? hcb_pkg::S_P_DONE : hcb_pkg::S_P_RD;
			end
			hcb_pkg::S_P_DONE: state_d = hcb_pkg::S_IDLE;
			default:           state_d = hcb_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: sv/hcb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder datapath
// Frequency, node, pool, path and code memories with their counters and the
// result registers, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module hcb_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire hcb_pkg::cmd_t               cmd,
	input  wire logic [hcb_pkg::SYM_W-1:0]   symbol,
	input  wire logic [hcb_pkg::FREQ_W-1:0]  frequency,
	input  wire logic                        bit_in,
	output hcb_pkg::sts_t                    sts,
	output logic [1:0]                       status,
	output logic [hcb_pkg::CODE_W-1:0]       code_bits,
	output logic [hcb_pkg::LEN_W-1:0]        code_length,
	output logic [hcb_pkg::SYM_W-1:0]        decoded_symbol,
	output logic                             symbol_found,
	output logic                             done
);

	localparam int SW = hcb_pkg::SYM_W;
	localparam int NW = hcb_pkg::NODE_W;
	localparam int WW = hcb_pkg::WEIGHT_W;
	localparam logic [hcb_pkg::PLEN_W-1:0] PLEN1 = hcb_pkg::PLEN_W'(1);

	logic [hcb_pkg::FREQ_W-1:0] freq_mem [hcb_pkg::NUM_SYMBOLS];
	hcb_pkg::node_t             node_mem [hcb_pkg::NUM_NODES];
	hcb_pkg::pool_t             pool_mem [hcb_pkg::NUM_NODES];
	hcb_pkg::path_t             path_mem [hcb_pkg::NUM_NODES];
	hcb_pkg::code_t             code_mem [hcb_pkg::NUM_SYMBOLS];

	logic [hcb_pkg::NUM_SYMBOLS-1:0] freq_valid_q;
	logic [hcb_pkg::NUM_SYMBOLS-1:0] code_valid_q;

	logic [hcb_pkg::FREQ_W-1:0] freq_rd_q;
	hcb_pkg::node_t             node_rd_q;
	hcb_pkg::pool_t             pool_rd_q;
	hcb_pkg::path_t             path_rd_q;
	hcb_pkg::code_t             code_rd_q;

	logic [SW-1:0] sym_q;
	logic          bit_q;
	logic [hcb_pkg::FREQ_W-1:0] frequency_q;
	logic [SW-1:0] sym_cnt_q;
	logic [NW-1:0] used_q;
	logic [NW-1:0] count_q;
	logic [NW-1:0] k_q;
	logic [NW-1:0] i_q;
	logic [NW-1:0] slot_q;
	logic [WW-1:0] best_w_q;
	logic [NW-1:0] best_idx_q;
	logic [WW-1:0] a_w_q;
	logic [NW-1:0] a_idx_q;
	logic          first_q;
	logic          second_q;
	logic          too_long_q;
	logic          built_q;
	logic [NW-1:0] root_q;
	logic          root_leaf_q;
	logic [SW-1:0] root_sym_q;
	logic [NW-1:0] decode_q;
	logic [NW-1:0] nxt_q;

	logic [NW-1:0]  node_raddr;
	logic [NW-1:0]  pool_raddr;
	logic [NW-1:0]  nxt;
	logic           node_we;
	hcb_pkg::node_t node_wdata;
	logic           pool_we;
	logic [NW-1:0]  pool_waddr;
	hcb_pkg::pool_t pool_wdata;
	logic           path_we;
	logic [NW-1:0]  path_waddr;
	hcb_pkg::path_t path_wdata;
	logic [hcb_pkg::FREQ_W-1:0] leaf_freq;
	logic           better;

	assign nxt       = bit_q ? node_rd_q.c1 : node_rd_q.c0;
	assign leaf_freq = freq_valid_q[sym_cnt_q] ? freq_rd_q : '0;
	assign better    = first_q || (pool_rd_q.weight < best_w_q) ||
		((pool_rd_q.weight == best_w_q) && (pool_rd_q.idx < best_idx_q));

	always_comb begin
		case (cmd.op)
			hcb_pkg::S_DEC_A: node_raddr = decode_q;
			hcb_pkg::S_DEC_B: node_raddr = nxt;
			default:          node_raddr = i_q;
		endcase
		case (cmd.op)
			hcb_pkg::S_SCAN:   pool_raddr = k_q + NW'(1);
			hcb_pkg::S_REMOVE: pool_raddr = count_q - NW'(1);
			default:           pool_raddr = '0;
		endcase
		node_we    = 1'b0;
		node_wdata = '0;
		pool_we    = 1'b0;
		pool_waddr = count_q;
		pool_wdata = '0;
		path_we    = 1'b0;
		path_waddr = '0;
		path_wdata = '0;
		case (cmd.op)
			hcb_pkg::S_LEAF_WR: begin
				node_we         = (leaf_freq != '0);
				node_wdata.leaf = 1'b1;
				node_wdata.sym  = sym_cnt_q;
				pool_we         = (leaf_freq != '0);
				pool_wdata      = '{weight: WW'(leaf_freq), idx: used_q};
			end
			hcb_pkg::S_MOVE: begin
				pool_we    = 1'b1;
				pool_waddr = slot_q;
				pool_wdata = pool_rd_q;
			end
			hcb_pkg::S_MERGE: begin
				node_we       = 1'b1;
				node_wdata.c0 = a_idx_q;
				node_wdata.c1 = best_idx_q;
				pool_we       = 1'b1;
				pool_wdata    = '{weight: a_w_q + best_w_q, idx: used_q};
			end
			hcb_pkg::S_B_ROOT: begin
				path_we    = 1'b1;
				path_waddr = used_q - NW'(1);
			end
			hcb_pkg::S_P_EVAL: begin
				path_we    = !node_rd_q.leaf;
				path_waddr = node_rd_q.c0;
				path_wdata = '{bits: path_rd_q.bits << 1, len: path_rd_q.len + PLEN1};
			end
			hcb_pkg::S_P_ONE: begin
				path_we    = 1'b1;
				path_waddr = node_rd_q.c1;
				path_wdata = '{bits: (path_rd_q.bits << 1) | hcb_pkg::CODE_W'(1),
					len: path_rd_q.len + PLEN1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		freq_rd_q <= freq_mem[sym_cnt_q];
		node_rd_q <= node_mem[node_raddr];
		pool_rd_q <= pool_mem[pool_raddr];
		path_rd_q <= path_mem[i_q];
		code_rd_q <= code_mem[sym_q];
		if (cmd.op == hcb_pkg::S_LOAD) begin
			freq_mem[sym_q] <= frequency_q;
		end
		if (node_we) begin
			node_mem[used_q] <= node_wdata;
		end
		if (pool_we) begin
			pool_mem[pool_waddr] <= pool_wdata;
		end
		if (path_we) begin
			path_mem[path_waddr] <= path_wdata;
		end
		if (cmd.op == hcb_pkg::S_P_EVAL && node_rd_q.leaf) begin
			code_mem[node_rd_q.sym] <= '{bits: path_rd_q.bits,
				len: path_rd_q.len[hcb_pkg::LEN_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q       <= symbol;
			bit_q       <= bit_in;
			frequency_q <= frequency;
		end
		if (cmd.op == hcb_pkg::S_DEC_B) begin
			nxt_q <= nxt;
		end
		case (cmd.op)
			hcb_pkg::S_SCAN_START: begin
				k_q     <= '0;
				first_q <= 1'b1;
			end
			hcb_pkg::S_SCAN: begin
				first_q <= 1'b0;
				k_q     <= k_q + NW'(1);
				if (better) begin
					best_w_q   <= pool_rd_q.weight;
					best_idx_q <= pool_rd_q.idx;
					slot_q     <= k_q;
				end
			end
			hcb_pkg::S_MOVE: begin
				if (!second_q) begin
					a_w_q   <= best_w_q;
					a_idx_q <= best_idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_valid_q   <= '0;
			code_valid_q   <= '0;
			sym_cnt_q      <= '0;
			used_q         <= '0;
			count_q        <= '0;
			i_q            <= '0;
			second_q       <= 1'b0;
			too_long_q     <= 1'b0;
			built_q        <= 1'b0;
			root_q         <= '0;
			root_leaf_q    <= 1'b0;
			root_sym_q     <= '0;
			decode_q       <= '0;
			done           <= 1'b0;
			status         <= '0;
			code_bits      <= '0;
			code_length    <= '0;
			decoded_symbol <= '0;
			symbol_found   <= 1'b0;
		end else begin
			done           <= 1'b0;
			status         <= hcb_pkg::ST_OK;
			code_bits      <= '0;
			code_length    <= '0;
			decoded_symbol <= '0;
			symbol_found   <= 1'b0;
			case (cmd.op)
				hcb_pkg::S_LOAD: begin
					freq_valid_q[sym_q] <= 1'b1;
					done                <= 1'b1;
				end
				hcb_pkg::S_RD_B: begin
					done <= 1'b1;
					if (built_q && code_valid_q[sym_q]) begin
						code_bits   <= code_rd_q.bits;
						code_length <= code_rd_q.len;
					end else begin
						status <= hcb_pkg::ST_NOT_FOUND;
					end
				end
				hcb_pkg::S_DEC_A: begin
					if (!built_q) begin
						done   <= 1'b1;
						status <= hcb_pkg::ST_NOT_FOUND;
					end else if (root_leaf_q) begin
						done           <= 1'b1;
						decoded_symbol <= root_sym_q;
						symbol_found   <= 1'b1;
						decode_q       <= root_q;
					end
				end
				hcb_pkg::S_DEC_C: begin
					done <= 1'b1;
					if (node_rd_q.leaf) begin
						decoded_symbol <= node_rd_q.sym;
						symbol_found   <= 1'b1;
						decode_q       <= root_q;
					end else begin
						decode_q <= nxt_q;
					end
				end
				hcb_pkg::S_B_INIT: begin
					code_valid_q <= '0;
					sym_cnt_q    <= '0;
					used_q       <= '0;
					count_q      <= '0;
					second_q     <= 1'b0;
				end
				hcb_pkg::S_LEAF_WR: begin
					sym_cnt_q <= sym_cnt_q + SW'(1);
					if (leaf_freq != '0) begin
						used_q  <= used_q + NW'(1);
						count_q <= count_q + NW'(1);
					end
				end
				hcb_pkg::S_B_CHECK: begin
					if (count_q == '0) begin
						done    <= 1'b1;
						status  <= hcb_pkg::ST_EMPTY;
						built_q <= 1'b0;
					end
				end
				hcb_pkg::S_MOVE: begin
					count_q  <= count_q - NW'(1);
					second_q <= 1'b1;
				end
				hcb_pkg::S_MERGE: begin
					used_q   <= used_q + NW'(1);
					count_q  <= count_q + NW'(1);
					second_q <= 1'b0;
				end
				hcb_pkg::S_B_ROOT: begin
					i_q         <= used_q - NW'(1);
					root_q      <= used_q - NW'(1);
					decode_q    <= used_q - NW'(1);
					root_leaf_q <= (used_q == NW'(1));
					too_long_q  <= 1'b0;
				end
				hcb_pkg::S_P_EVAL: begin
					if (node_rd_q.leaf) begin
						code_valid_q[node_rd_q.sym] <= 1'b1;
						if (path_rd_q.len > hcb_pkg::PLEN_W'(hcb_pkg::MAX_CODE_LEN)) begin
							too_long_q <= 1'b1;
						end
						if (i_q == root_q) begin
							root_sym_q <= node_rd_q.sym;
						end
						i_q <= i_q - NW'(1);
					end
				end
				hcb_pkg::S_P_ONE: begin
					i_q <= i_q - NW'(1);
				end
				hcb_pkg::S_P_DONE: begin
					done <= 1'b1;
					if (too_long_q) begin
						status       <= hcb_pkg::ST_TOO_LONG;
						code_valid_q <= '0;
						built_q      <= 1'b0;
					end else begin
						built_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		sts.sym_last   = (sym_cnt_q == '1);
		sts.pool_empty = (count_q == '0);
		sts.pool_one   = (count_q == NW'(1));
		sts.scan_last  = (k_q == count_q - NW'(1));
		sts.second     = second_q;
		sts.built      = built_q;
		sts.root_leaf  = root_leaf_q;
		sts.node_leaf  = node_rd_q.leaf;
		sts.idx_zero   = (i_q == '0);
	end

endmodule
`default_nettype wire

// File: sv/huffman_code_builder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder unit
// Builds a Huffman code from loaded symbol frequencies, reads codes back and
// decodes a bit stream one bit per command.
// ----------------------------------------------------------------------------
// Usage: raise start with action and its operands; the beat is taken at a
// rising edge where start is high and busy is low. Every command gives one
// result beat, marked by done for exactly one cycle, on status, code_bits,
// code_length, decoded_symbol and symbol_found. The receiver cannot stall.
// A build walks the frequency memory one symbol at a time, then for each
// merge scans the candidate pool twice through its single read port, then
// assigns paths node by node. The next command may be given in the cycle
// where done is shown.
// Reset clears the valid bits of the frequency and code tables, the built flag
// and the decoder position at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_code_builder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  symbol,
	input  wire logic [23:0] frequency,
	input  wire logic        bit_in,
	output logic             done,
	output logic [1:0]       status,
	output logic [31:0]      code_bits,
	output logic [5:0]       code_length,
	output logic [7:0]       decoded_symbol,
	output logic             symbol_found
);

	hcb_pkg::cmd_t cmd;
	hcb_pkg::sts_t sts;

	hcb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	hcb_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.symbol         (symbol),
		.frequency      (frequency),
		.bit_in         (bit_in),
		.sts            (sts),
		.status         (status),
		.code_bits      (code_bits),
		.code_length    (code_length),
		.decoded_symbol (decoded_symbol),
		.symbol_found   (symbol_found),
		.done           (done)
	);

endmodule
`default_nettype wire
